// File: design/assert_macros.svh
// Assertion macros included by the tap generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GLTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GLTG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define GLTG_ASSERT(lbl, prop, msg)
`define GLTG_NEVER(lbl, cond, msg)
`endif
`endif

// File: design/gltg_pkg.sv
// Constants for the gaussian linear tap generator.
`timescale 1ns / 1ps
`default_nettype none
package gltg_pkg;
  localparam int unsigned RadW    = 6;
  localparam int unsigned OffW    = 22;
  localparam int unsigned WtW     = 25;
  localparam int unsigned CntW    = 5;
  localparam int unsigned StoreW  = 24;
  localparam int unsigned TotW    = 32;
  localparam int unsigned DivW    = 50;
  localparam int unsigned DivCntW = 6;
  localparam logic [30:0] Q30One  = 31'h4000_0000;
  localparam logic [31:0] Q24One  = 32'h0100_0000;
  localparam logic [DivCntW-1:0] DivBitsExp  = 6'd42;
  localparam logic [DivCntW-1:0] DivBitsPoly = 6'd31;
  localparam logic [DivCntW-1:0] DivBitsOut  = 6'd50;
  localparam logic [RadW-1:0] ResetMaxRadius = 6'd32;
endpackage
`default_nettype wire

// File: design/gaussian_linear_tap_generator.sv
// Gaussian linear-sampled tap generator: weight sequencer, weight memory, serial divider.
// One request at a time. Per offset: an exponent divide, ten Horner steps with a divide
// each, and three squarings; the centre result follows, then each pair tap with a weight
// and an offset divide and a lone final tap with a weight divide, plus output stalls.
// Reset clears control and max_radius (to 32); the weight memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_linear_tap_generator #(
  parameter int MAX_RADIUS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [gltg_pkg::RadW-1:0]  max_radius_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [gltg_pkg::RadW-1:0]  radius_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            kind_o,
  output logic [gltg_pkg::OffW-1:0]       tap_offset_o,
  output logic [gltg_pkg::WtW-1:0]        tap_weight_o,
  output logic [gltg_pkg::CntW-1:0]       tap_count_o,
  output logic                            last_o
);
  import gltg_pkg::*;
  `include "assert_macros.svh"

  localparam int Built = (MAX_RADIUS > 32) ? 32 : MAX_RADIUS;
  localparam int Depth = Built + 1;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [RadW-1:0] BuiltR = RadW'(Built);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PREP  = 5'd1;
  localparam logic [4:0] S_QDIV  = 5'd2;
  localparam logic [4:0] S_QWAIT = 5'd3;
  localparam logic [4:0] S_HMUL  = 5'd4;
  localparam logic [4:0] S_HDIV  = 5'd5;
  localparam logic [4:0] S_HWAIT = 5'd6;
  localparam logic [4:0] S_SQ    = 5'd7;
  localparam logic [4:0] S_SQW   = 5'd8;
  localparam logic [4:0] S_WR    = 5'd9;
  localparam logic [4:0] S_CEN   = 5'd10;
  localparam logic [4:0] S_CENW  = 5'd11;
  localparam logic [4:0] S_TAP   = 5'd12;
  localparam logic [4:0] S_RDA   = 5'd13;
  localparam logic [4:0] S_RDB   = 5'd14;
  localparam logic [4:0] S_SRD   = 5'd15;
  localparam logic [4:0] S_WDIV  = 5'd16;
  localparam logic [4:0] S_WWAIT = 5'd17;
  localparam logic [4:0] S_ODIV  = 5'd18;
  localparam logic [4:0] S_OWAIT = 5'd19;
  localparam logic [4:0] S_EMIT  = 5'd20;

  logic [4:0] state_q, state_d;
  logic [RadW-1:0] max_radius_q;
  logic [RadW-1:0] r_q, r_d;
  logic [6:0] r2_q, r2_d;
  logic [12:0] r2sq_q;
  logic [RadW-1:0] i_q, i_d;
  logic [3:0] n_q, n_d;
  logic [1:0] sq_q, sq_d;
  logic [30:0] qv_q, qv_d;
  logic [30:0] t_q, t_d;
  logic [61:0] prod_q;
  logic [TotW-1:0] total_q, total_d;
  logic [StoreW-1:0] a_q, a_d;
  logic [WtW-1:0] s_q, s_d;
  logic [30:0] onum_q, onum_d;
  logic [WtW-1:0] wt_q, wt_d;
  logic [OffW-1:0] off_q, off_d;
  logic single_q, single_d;

  // Weight memory, one write and one read port, registered read.
  logic [StoreW-1:0] mem [Depth];
  logic [StoreW-1:0] rd_q;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [StoreW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  // Restoring divider, one quotient bit per cycle; quotient lands in div_num_q.
  logic [DivW-1:0] div_num_q, div_num_in;
  logic [32:0] div_rem_q;
  logic [31:0] div_den_q, div_den_in;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_in;
  logic div_load;
  logic [32:0] rem_sh, rem_sub;
  logic rem_ge;

  always_comb begin
    rem_sh  = {div_rem_q[31:0], div_num_q[DivW-1]};
    rem_ge  = rem_sh >= {1'b0, div_den_q};
    rem_sub = rem_sh - {1'b0, div_den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_load) begin
      div_cnt_q <= div_cnt_in;
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_load) begin
      div_num_q <= div_num_in;
      div_rem_q <= '0;
      div_den_q <= div_den_in;
    end else if (div_cnt_q != '0) begin
      div_num_q <= {div_num_q[DivW-2:0], rem_ge};
      div_rem_q <= rem_ge ? rem_sub : rem_sh;
    end
  end

  logic div_done;
  assign div_done = (div_cnt_q == '0);

  // Output register.
  logic out_valid_q;
  logic kind_q, last_q;
  logic [OffW-1:0] tap_offset_q;
  logic [WtW-1:0] tap_weight_q;
  logic [CntW-1:0] tap_count_q;
  logic emit, can_emit;
  logic emit_kind, emit_last;
  logic [OffW-1:0] emit_off;
  logic [WtW-1:0] emit_wt;

  assign can_emit = !out_valid_q || out_ready_i;

  // Request decode.
  logic [RadW-1:0] lim, r_clamp;
  logic [CntW-1:0] taps;
  logic [14:0] ii18;
  logic [31:0] tp;
  logic [StoreW-1:0] w24;
  logic [29:0] prod_a, prod_b;

  always_comb begin
    lim     = (max_radius_q < BuiltR) ? max_radius_q : BuiltR;
    r_clamp = (radius_i > lim) ? lim : radius_i;
    taps    = CntW'(({1'b0, r_q} + 7'd1) >> 1);
    ii18    = 15'(i_q) * 15'(i_q) * 15'd18;
    tp      = {1'b0, t_q} + 32'd32;
    w24     = tp[29:6];
    prod_a  = 30'(a_q) * 30'(i_q);
    prod_b  = 30'(rd_q) * 30'({1'b0, i_q} + 7'd1);
  end

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    r2_d       = r2_q;
    i_d        = i_q;
    n_d        = n_q;
    sq_d       = sq_q;
    qv_d       = qv_q;
    t_d        = t_q;
    total_d    = total_q;
    a_d        = a_q;
    s_d        = s_q;
    onum_d     = onum_q;
    wt_d       = wt_q;
    off_d      = off_q;
    single_d   = single_q;
    div_load   = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    div_cnt_in = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = i_q[AW-1:0];
    mem_raddr  = i_q[AW-1:0];
    mem_wdata  = w24;
    emit       = 1'b0;
    emit_kind  = 1'b1;
    emit_off   = off_q;
    emit_wt    = wt_q;
    emit_last  = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          r_d     = r_clamp;
          r2_d    = ({1'b0, r_clamp, 1'b0} < 8'd3) ? 7'd3 : {r_clamp, 1'b0};
          i_d     = 6'd1;
          total_d = Q24One;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = (r_q == '0) ? S_CEN : S_QDIV;
      end
      S_QDIV: begin
        div_load   = 1'b1;
        div_num_in = {ii18, 35'd0};
        div_den_in = {19'd0, r2sq_q};
        div_cnt_in = DivBitsExp;
        state_d    = S_QWAIT;
      end
      S_QWAIT: begin
        if (div_done) begin
          qv_d    = (div_num_q > DivW'(Q30One)) ? Q30One : div_num_q[30:0];
          t_d     = Q30One;
          n_d     = 4'd10;
          state_d = S_HMUL;
        end
      end
      S_HMUL: begin
        state_d = S_HDIV;
      end
      S_HDIV: begin
        div_load   = 1'b1;
        div_num_in = {prod_q[60:30], 19'd0};
        div_den_in = {28'd0, n_q};
        div_cnt_in = DivBitsPoly;
        state_d    = S_HWAIT;
      end
      S_HWAIT: begin
        if (div_done) begin
          t_d = Q30One - div_num_q[30:0];
          if (n_q == 4'd1) begin
            sq_d    = 2'd3;
            state_d = S_SQ;
          end else begin
            n_d     = n_q - 4'd1;
            state_d = S_HMUL;
          end
        end
      end
      S_SQ: begin
        state_d = S_SQW;
      end
      S_SQW: begin
        t_d     = prod_q[60:30];
        sq_d    = sq_q - 2'd1;
        state_d = (sq_q == 2'd1) ? S_WR : S_SQ;
      end
      S_WR: begin
        mem_we  = 1'b1;
        total_d = total_q + {7'd0, w24, 1'b0};
        if (i_q == r_q) begin
          i_d     = 6'd1;
          state_d = S_CEN;
        end else begin
          i_d     = i_q + 6'd1;
          state_d = S_QDIV;
        end
      end
      S_CEN: begin
        div_load   = 1'b1;
        div_num_in = {2'b01, 48'd0} + {19'd0, total_q[31:1]};
        div_den_in = total_q;
        div_cnt_in = DivBitsOut;
        state_d    = S_CENW;
      end
      S_CENW: begin
        if (div_done && can_emit) begin
          emit      = 1'b1;
          emit_kind = 1'b0;
          emit_off  = '0;
          emit_wt   = div_num_q[WtW-1:0];
          emit_last = (taps == '0);
          i_d       = 6'd1;
          state_d   = (taps == '0) ? S_IDLE : S_TAP;
        end
      end
      S_TAP: begin
        if (({1'b0, i_q} + 7'd1) <= {1'b0, r_q}) begin
          mem_re   = 1'b1;
          single_d = 1'b0;
          state_d  = S_RDA;
        end else if (i_q <= r_q) begin
          mem_re   = 1'b1;
          single_d = 1'b1;
          state_d  = S_SRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RDA: begin
        a_d       = rd_q;
        mem_re    = 1'b1;
        mem_raddr = AW'(i_q + 6'd1);
        state_d   = S_RDB;
      end
      S_RDB: begin
        s_d     = {1'b0, a_q} + {1'b0, rd_q};
        onum_d  = {1'b0, prod_a} + {1'b0, prod_b};
        state_d = S_WDIV;
      end
      S_SRD: begin
        s_d     = {1'b0, rd_q};
        off_d   = {i_q, 16'd0};
        state_d = S_WDIV;
      end
      S_WDIV: begin
        div_load   = 1'b1;
        div_num_in = {1'b0, s_q, 24'd0} + {19'd0, total_q[31:1]};
        div_den_in = total_q;
        div_cnt_in = DivBitsOut;
        state_d    = S_WWAIT;
      end
      S_WWAIT: begin
        if (div_done) begin
          wt_d = div_num_q[WtW-1:0];
          if (single_q) begin
            state_d = S_EMIT;
          end else if (s_q == '0) begin
            off_d   = {i_q, 16'd0};
            state_d = S_EMIT;
          end else begin
            state_d = S_ODIV;
          end
        end
      end
      S_ODIV: begin
        div_load   = 1'b1;
        div_num_in = {3'd0, onum_q, 16'd0} + {26'd0, s_q[WtW-1:1]};
        div_den_in = {7'd0, s_q};
        div_cnt_in = DivBitsOut;
        state_d    = S_OWAIT;
      end
      S_OWAIT: begin
        if (div_done) begin
          off_d   = div_num_q[OffW-1:0];
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_last = single_q || (CntW'(({1'b0, i_q} + 7'd1) >> 1) == taps);
          i_d       = i_q + 6'd2;
          state_d   = S_TAP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_radius_q <= ResetMaxRadius;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) max_radius_q <= max_radius_i;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    r2_q     <= r2_d;
    r2sq_q   <= 13'(r2_q) * 13'(r2_q);
    i_q      <= i_d;
    n_q      <= n_d;
    sq_q     <= sq_d;
    qv_q     <= qv_d;
    t_q      <= t_d;
    total_q  <= total_d;
    a_q      <= a_d;
    s_q      <= s_d;
    onum_q   <= onum_d;
    wt_q     <= wt_d;
    off_q    <= off_d;
    single_q <= single_d;
    if (state_q == S_SQ) prod_q <= 62'(t_q) * 62'(t_q);
    else prod_q <= 62'(qv_q) * 62'(t_q);
    if (emit) begin
      kind_q       <= emit_kind;
      tap_offset_q <= emit_off;
      tap_weight_q <= emit_wt;
      tap_count_q  <= taps;
      last_q       <= emit_last;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign tap_offset_o = tap_offset_q;
  assign tap_weight_o = tap_weight_q;
  assign tap_count_o  = tap_count_q;
  assign last_o       = last_q;

  `GLTG_NEVER(a_idle_div_busy, in_ready_o && !div_done, "divider busy while idle")
  `GLTG_NEVER(a_emit_overwrite, emit && out_valid_q && !out_ready_i, "result overwritten")
  `GLTG_ASSERT(a_one_request, (in_valid_i && in_ready_o) |=> !in_ready_o, "second request taken")
  `GLTG_NEVER(a_mem_rw, mem_we && mem_re, "weight memory read during write")
endmodule
`default_nettype wire
